// File: src/tmq_pkg.sv
// Shared widths, register indexes and reset values of the tile map quad generator.
package tmq_pkg;

    localparam int TILE_W     = 8;
    localparam int SIZE_W     = 9;
    localparam int LVL_W      = 7;
    localparam int OFS_W      = 12;
    localparam int CFG_DATA_W = 12;
    localparam int CFG_IDX_W  = 3;
    localparam int VIDX_W     = 14;
    localparam int CORNER_W   = 2;
    localparam int POS_W      = 16;
    localparam int TEX_W      = 17;
    localparam int MUL_A_W    = 8;
    localparam int PROD_W     = MUL_A_W + SIZE_W;

    localparam int DEF_MAX_LEVEL_DIM = 64;

    localparam logic [CFG_IDX_W-1:0] CFG_TILE_WIDTH      = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TILE_HEIGHT     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_TILESET_COLUMNS = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_LEVEL_WIDTH     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_LEVEL_HEIGHT    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_OFFSET_X        = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_OFFSET_Y        = 3'd6;

    localparam logic [SIZE_W-1:0] RST_TILE_WIDTH      = 9'd32;
    localparam logic [SIZE_W-1:0] RST_TILE_HEIGHT     = 9'd32;
    localparam logic [SIZE_W-1:0] RST_TILESET_COLUMNS = 9'd1;
    localparam logic [LVL_W-1:0]  RST_LEVEL_WIDTH     = 7'd9;
    localparam logic [LVL_W-1:0]  RST_LEVEL_HEIGHT    = 7'd9;

    localparam logic [CORNER_W-1:0] CORNER_TL = 2'd0;
    localparam logic [CORNER_W-1:0] CORNER_TR = 2'd1;
    localparam logic [CORNER_W-1:0] CORNER_BR = 2'd2;
    localparam logic [CORNER_W-1:0] CORNER_BL = 2'd3;

endpackage

// File: src/tmq_div.sv
// Restoring divider that splits a tile number into tileset row and column, one bit a cycle.
module tmq_div (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    input  logic [tmq_pkg::TILE_W-1:0] dividend,
    input  logic [tmq_pkg::SIZE_W-1:0] divisor,
    output logic                       done,
    output logic [tmq_pkg::TILE_W-1:0] quotient,
    output logic [tmq_pkg::TILE_W-1:0] remainder
);
    import tmq_pkg::*;

    localparam int STEP_W = $clog2(TILE_W);
    localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(TILE_W - 1);

    logic              busy_reg, busy_next;
    logic [STEP_W-1:0] step_reg, step_next;
    logic [TILE_W-1:0] quo_reg, quo_next;
    logic [SIZE_W-1:0] rem_reg, rem_next;
    logic [SIZE_W-1:0] dvs_reg, dvs_next;

    logic [SIZE_W:0]   shifted;
    logic [SIZE_W:0]   diff;
    logic              fits;

    // The partial remainder stays below the divisor, so one extra bit holds the shift.
    assign shifted = {rem_reg, quo_reg[TILE_W-1]};
    assign diff    = shifted - {1'b0, dvs_reg};
    assign fits    = shifted >= {1'b0, dvs_reg};

    always_comb
    begin
        busy_next = busy_reg;
        step_next = step_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        if (start)
        begin
            busy_next = 1'b1;
            step_next = '0;
            quo_next  = dividend;
            rem_next  = '0;
            dvs_next  = divisor;
        end
        else if (busy_reg)
        begin
            rem_next  = fits ? diff[SIZE_W-1:0] : shifted[SIZE_W-1:0];
            quo_next  = {quo_reg[TILE_W-2:0], fits};
            step_next = step_reg + 1'b1;
            if (step_reg == LAST_STEP)
            begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            step_reg <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
    end

    assign done      = busy_reg && (step_reg == LAST_STEP);
    assign quotient  = quo_reg;
    assign remainder = rem_reg[TILE_W-1:0];

endmodule

// File: src/tile_map_quad_generator_unit.sv
// Tile map quad generator: turns tile numbers in scan order into four quad vertices each.
//
// Input channel: one beat carries a tile number, taken in scan order, column by
// column and top to bottom within a column. Output channel: four beats per tile,
// corners 0 to 3, each with vertex index, screen position and texture coordinate;
// last_of_tile marks corner 3 and last_of_level marks corner 3 of the level's
// final tile, for which the column and row counters wrap to zero. The user must
// write configuration via cfg_write/cfg_index/cfg_data only while idle; not enforced.
//
// Flow: a tile goes from its input beat through the bit-serial divider for the
// tileset row and column, then the shared 8x9 multiplier for the texture products,
// U then V, then 4 output beats. The screen and index products go through the
// same multiplier while the divider runs. in_stall is high after the input beat
// until the fourth vertex has left, so the block takes no new tile before then.
// A stalled output beat holds its value and simply lengthens the tile.
// Reset restores the default register values and clears both counters.
module tile_map_quad_generator_unit #(
    parameter int MAX_LEVEL_DIM = tmq_pkg::DEF_MAX_LEVEL_DIM
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_write,
    input  logic [tmq_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [tmq_pkg::CFG_DATA_W-1:0]      cfg_data,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic [tmq_pkg::TILE_W-1:0]          tile_number,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic [tmq_pkg::VIDX_W-1:0]          vertex_index,
    output logic [tmq_pkg::CORNER_W-1:0]        corner,
    output logic signed [tmq_pkg::POS_W-1:0]    pos_x,
    output logic signed [tmq_pkg::POS_W-1:0]    pos_y,
    output logic [tmq_pkg::TEX_W-1:0]           tex_u,
    output logic [tmq_pkg::TEX_W-1:0]           tex_v,
    output logic                                last_of_tile,
    output logic                                last_of_level
);
    import tmq_pkg::*;

    localparam int CW  = (MAX_LEVEL_DIM > 1) ? $clog2(MAX_LEVEL_DIM) : 1;
    localparam int WW  = $clog2(MAX_LEVEL_DIM + 1);
    localparam int SUM_W = PROD_W + 2;
    localparam logic [SIZE_W-1:0] MAX_DIM = SIZE_W'(MAX_LEVEL_DIM);

    typedef enum logic [4:0] {
        ST_IDLE  = 5'b00001,
        ST_DIV   = 5'b00010,
        ST_MUL_U = 5'b00100,
        ST_MUL_V = 5'b01000,
        ST_EMIT  = 5'b10000
    } state_t;

    state_t state_reg, state_next;

    logic [SIZE_W-1:0]       tile_width_reg, tile_height_reg, tileset_columns_reg;
    logic [LVL_W-1:0]        level_width_reg, level_height_reg;
    logic signed [OFS_W-1:0] offset_x_reg, offset_y_reg;

    logic [CW-1:0]       col_reg, col_next;
    logic [CW-1:0]       row_reg, row_next;
    logic [2:0]          mstep_reg, mstep_next;
    logic [CORNER_W-1:0] corner_reg, corner_next;
    logic                level_end_reg, level_end_next;

    logic [PROD_W-1:0]   px_reg, py_reg, idx_reg, tu_reg, tv_reg;

    logic                in_beat, out_beat;
    logic [SIZE_W-1:0]   cols;
    logic [SIZE_W-1:0]   lw_ext, lh_ext, lw_dim, lh_dim;
    logic [WW-1:0]       lvl_w;
    logic [SIZE_W-1:0]   col_p1, row_p1;
    logic                col_wrap, row_wrap;

    logic                div_done;
    logic [TILE_W-1:0]   div_quo, div_rem;

    logic [MUL_A_W-1:0]  mul_a;
    logic [SIZE_W-1:0]   mul_b;
    logic [PROD_W-1:0]   mul_p;

    logic                dx, dy;
    logic signed [SUM_W-1:0] x_sum, y_sum;
    logic [PROD_W:0]     u_sum, v_sum;

    assign in_beat  = in_valid && !in_stall;
    assign out_beat = out_valid && !out_stall;
    assign in_stall = (state_reg != ST_IDLE);
    assign out_valid = (state_reg == ST_EMIT);

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tile_width_reg      <= RST_TILE_WIDTH;
            tile_height_reg     <= RST_TILE_HEIGHT;
            tileset_columns_reg <= RST_TILESET_COLUMNS;
            level_width_reg     <= RST_LEVEL_WIDTH;
            level_height_reg    <= RST_LEVEL_HEIGHT;
            offset_x_reg        <= '0;
            offset_y_reg        <= '0;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                CFG_TILE_WIDTH:      tile_width_reg      <= cfg_data[SIZE_W-1:0];
                CFG_TILE_HEIGHT:     tile_height_reg     <= cfg_data[SIZE_W-1:0];
                CFG_TILESET_COLUMNS: tileset_columns_reg <= cfg_data[SIZE_W-1:0];
                CFG_LEVEL_WIDTH:     level_width_reg     <= cfg_data[LVL_W-1:0];
                CFG_LEVEL_HEIGHT:    level_height_reg    <= cfg_data[LVL_W-1:0];
                CFG_OFFSET_X:        offset_x_reg        <= cfg_data[OFS_W-1:0];
                CFG_OFFSET_Y:        offset_y_reg        <= cfg_data[OFS_W-1:0];
                default:             ;
            endcase
        end
    end

    // A tileset column count of zero behaves as one; level sizes clamp to 1..MAX_LEVEL_DIM.
    assign cols   = (tileset_columns_reg == '0) ? SIZE_W'(1) : tileset_columns_reg;
    assign lw_ext = SIZE_W'(level_width_reg);
    assign lh_ext = SIZE_W'(level_height_reg);

    always_comb
    begin
        lw_dim = lw_ext;
        if (lw_ext == '0)
        begin
            lw_dim = SIZE_W'(1);
        end
        else if (lw_ext > MAX_DIM)
        begin
            lw_dim = MAX_DIM;
        end
        lh_dim = lh_ext;
        if (lh_ext == '0)
        begin
            lh_dim = SIZE_W'(1);
        end
        else if (lh_ext > MAX_DIM)
        begin
            lh_dim = MAX_DIM;
        end
    end

    assign lvl_w    = lw_dim[WW-1:0];
    assign col_p1   = SIZE_W'(col_reg) + SIZE_W'(1);
    assign row_p1   = SIZE_W'(row_reg) + SIZE_W'(1);
    assign col_wrap = col_p1 >= lw_dim;
    assign row_wrap = row_p1 >= lh_dim;

    tmq_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (in_beat),
        .dividend  (tile_number),
        .divisor   (cols),
        .done      (div_done),
        .quotient  (div_quo),
        .remainder (div_rem)
    );

    // Shared multiplier: screen and index products during the divide, texture after it.
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        if (state_reg == ST_DIV)
        begin
            case (mstep_reg)
                3'd0:
                begin
                    mul_a = MUL_A_W'(col_reg);
                    mul_b = tile_width_reg;
                end
                3'd1:
                begin
                    mul_a = MUL_A_W'(row_reg);
                    mul_b = tile_height_reg;
                end
                3'd2:
                begin
                    mul_a = MUL_A_W'(row_reg);
                    mul_b = SIZE_W'(lvl_w);
                end
                default:
                begin
                    mul_a = '0;
                    mul_b = '0;
                end
            endcase
        end
        else if (state_reg == ST_MUL_U)
        begin
            mul_a = div_rem;
            mul_b = tile_width_reg;
        end
        else if (state_reg == ST_MUL_V)
        begin
            mul_a = div_quo;
            mul_b = tile_height_reg;
        end
    end

    assign mul_p = mul_a * mul_b;

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_DIV)
        begin
            case (mstep_reg)
                3'd0:    px_reg  <= mul_p;
                3'd1:    py_reg  <= mul_p;
                3'd2:    idx_reg <= mul_p;
                3'd3:    idx_reg <= idx_reg + PROD_W'(col_reg);
                default: ;
            endcase
        end
        if (state_reg == ST_MUL_U)
        begin
            tu_reg <= mul_p;
        end
        if (state_reg == ST_MUL_V)
        begin
            tv_reg <= mul_p;
        end
    end

    // Sequencer.
    always_comb
    begin
        state_next     = state_reg;
        mstep_next     = mstep_reg;
        corner_next    = corner_reg;
        col_next       = col_reg;
        row_next       = row_reg;
        level_end_next = level_end_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_beat)
                begin
                    state_next = ST_DIV;
                    mstep_next = '0;
                end
            end
            ST_DIV:
            begin
                if (mstep_reg != 3'd4)
                begin
                    mstep_next = mstep_reg + 3'd1;
                end
                if (div_done)
                begin
                    state_next = ST_MUL_U;
                end
            end
            ST_MUL_U:
            begin
                state_next = ST_MUL_V;
            end
            ST_MUL_V:
            begin
                // The counters advance here; every product of this tile already holds them.
                state_next     = ST_EMIT;
                corner_next    = CORNER_TL;
                level_end_next = row_wrap && col_wrap;
                if (row_wrap)
                begin
                    row_next = '0;
                    col_next = col_wrap ? '0 : col_p1[CW-1:0];
                end
                else
                begin
                    row_next = row_p1[CW-1:0];
                end
            end
            ST_EMIT:
            begin
                if (out_beat)
                begin
                    corner_next = corner_reg + 1'b1;
                    if (corner_reg == CORNER_BL)
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            mstep_reg     <= '0;
            corner_reg    <= CORNER_TL;
            col_reg       <= '0;
            row_reg       <= '0;
            level_end_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            mstep_reg     <= mstep_next;
            corner_reg    <= corner_next;
            col_reg       <= col_next;
            row_reg       <= row_next;
            level_end_reg <= level_end_next;
        end
    end

    // Corner offsets: right edge for corners 1 and 2, bottom edge for corners 2 and 3.
    assign dx = (corner_reg == CORNER_TR) || (corner_reg == CORNER_BR);
    assign dy = (corner_reg == CORNER_BR) || (corner_reg == CORNER_BL);

    assign x_sum = $signed(SUM_W'(px_reg)) + $signed(SUM_W'(dx ? tile_width_reg : '0))
                 + $signed({{(SUM_W-OFS_W){offset_x_reg[OFS_W-1]}}, offset_x_reg});
    assign y_sum = $signed(SUM_W'(py_reg)) + $signed(SUM_W'(dy ? tile_height_reg : '0))
                 + $signed({{(SUM_W-OFS_W){offset_y_reg[OFS_W-1]}}, offset_y_reg});
    assign u_sum = (PROD_W+1)'(tu_reg) + (PROD_W+1)'(dx ? tile_width_reg : '0);
    assign v_sum = (PROD_W+1)'(tv_reg) + (PROD_W+1)'(dy ? tile_height_reg : '0);

    always_comb
    begin
        if (x_sum > $signed(SUM_W'(32767)))
        begin
            pos_x = 16'sh7FFF;
        end
        else if (x_sum < -$signed(SUM_W'(32768)))
        begin
            pos_x = 16'sh8000;
        end
        else
        begin
            pos_x = x_sum[POS_W-1:0];
        end
        if (y_sum > $signed(SUM_W'(32767)))
        begin
            pos_y = 16'sh7FFF;
        end
        else if (y_sum < -$signed(SUM_W'(32768)))
        begin
            pos_y = 16'sh8000;
        end
        else
        begin
            pos_y = y_sum[POS_W-1:0];
        end
    end

    assign tex_u = (u_sum[PROD_W:TEX_W] != '0) ? '1 : u_sum[TEX_W-1:0];
    assign tex_v = (v_sum[PROD_W:TEX_W] != '0) ? '1 : v_sum[TEX_W-1:0];

    assign vertex_index  = {idx_reg[VIDX_W-CORNER_W-1:0], corner_reg};
    assign corner        = corner_reg;
    assign last_of_tile  = (corner_reg == CORNER_BL);
    assign last_of_level = (corner_reg == CORNER_BL) && level_end_reg;

endmodule
